[src/scv_pkg.sv]
// Shared types and constants for the shifted Chebyshev V* evaluator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package scv_pkg;

    localparam int X_W            = 32;   // argument width
    localparam int DEG_IN_W       = 9;    // degree field width
    localparam int OUT_W          = 48;   // result width
    localparam int DIG_W          = 24;   // multiplier digit width
    localparam int N_DIG          = OUT_W / DIG_W;
    localparam int DIG_IW         = (N_DIG > 1) ? $clog2(N_DIG) : 1;
    localparam int BIG_LOG        = 50;   // product magnitude clamp is 2^BIG_LOG
    localparam int DEF_MAX_DEGREE = 255;
    localparam int DEF_FRAC_BITS  = 28;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // result source picked at the end of an item
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_XZERO,
        SEL_V0,
        SEL_V1
    } t_sel;

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              mul;
        logic [DIG_IW-1:0] dig;
        logic              rnd;
        logic              upd;
        logic              finish;
        t_sel              sel;
    } t_dp_cmd;

    typedef struct packed {
        logic deg_neg;
        logic x_one;
        logic x_zero;
        logic n_zero;
        logic n_one;
        logic v1_ovf;
        logic step_ovf;
        logic cnt_last;
    } t_dp_status;

endpackage

[src/scv_ctrl.sv]
// Controller state machine for the shifted Chebyshev V* evaluator.
// Depends on scv_pkg (command/status structs, result select codes).
`timescale 1ns / 1ps

module scv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  scv_pkg::t_dp_status i_status,
    output scv_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_valid
);
    import scv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_MUL,
        S_RND,
        S_UPD,
        S_FIN
    } t_state;

    localparam logic [DIG_IW-1:0] LAST_DIG = DIG_IW'(N_DIG - 1);

    t_state            r_state, n_state;
    t_sel              r_sel, n_sel;
    logic [DIG_IW-1:0] r_dig, n_dig;
    logic              r_valid, n_valid;
    t_dp_cmd           cmd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_dig   = r_dig;
        n_valid = 1'b0;
        cmd     = '0;
        cmd.sel = r_sel;
        cmd.dig = r_dig;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                n_dig   = '0;
                n_state = S_FIN;
                if (i_status.deg_neg) begin
                    n_sel = SEL_ZERO;
                end else if (i_status.x_one) begin
                    n_sel = SEL_ONE;
                end else if (i_status.x_zero) begin
                    n_sel = SEL_XZERO;
                end else if (i_status.n_zero) begin
                    n_sel = SEL_V0;
                end else if (i_status.n_one || i_status.v1_ovf) begin
                    n_sel = SEL_V1;
                end else begin
                    n_sel   = SEL_V1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (r_dig == LAST_DIG) begin
                    n_state = S_RND;
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            S_RND: begin
                cmd.rnd = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_dig   = '0;
                if (i_status.step_ovf || i_status.cnt_last) begin
                    n_sel   = SEL_V1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                n_valid    = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_ZERO;
            r_dig   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_dig   <= n_dig;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

[src/scv_dpath.sv]
// Datapath for the shifted Chebyshev V* evaluator: operand setup, digit-serial
// multiplier, rounding, recurrence update and result register. Depends on scv_pkg.
`timescale 1ns / 1ps

module scv_dpath #(
    parameter int MAX_DEGREE = scv_pkg::DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = scv_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  scv_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [scv_pkg::X_W-1:0]      i_x_value,
    input  logic signed [scv_pkg::DEG_IN_W-1:0] i_degree,
    output scv_pkg::t_dp_status                 o_status,
    output logic signed [scv_pkg::OUT_W-1:0]    o_poly_value,
    output logic                                o_saturated
);
    import scv_pkg::*;

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int C_W   = (DEG_W > DEG_IN_W - 1) ? DEG_W : DEG_IN_W - 1;
    localparam int A_W   = (FRAC_BITS + 4 > 35) ? FRAC_BITS + 4 : 35;
    localparam int V_W   = (A_W > OUT_W) ? A_W : OUT_W;
    localparam int ACC_W = A_W + OUT_W + 1;
    localparam int M_W   = ACC_W - FRAC_BITS;
    localparam int S_W   = BIG_LOG + 2;
    localparam int N_W   = S_W + 1;
    localparam int Z_W   = (DEG_W + FRAC_BITS + 2 > OUT_W + 1) ?
                           DEG_W + FRAC_BITS + 2 : OUT_W + 1;

    localparam logic [C_W-1:0]          C_MAXDEG = C_W'(MAX_DEGREE);
    localparam logic signed [A_W-1:0]   C_ONE    = A_W'(1) << FRAC_BITS;
    localparam logic signed [A_W-1:0]   C_TWO    = C_ONE <<< 1;
    localparam logic signed [A_W-1:0]   C_THREE  = C_ONE + C_TWO;
    localparam logic [OUT_W-1:0]        C_ONE_O  = OUT_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0]        C_HALF   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [M_W-1:0]          C_BIG    = M_W'(1) << BIG_LOG;

    // item registers
    logic signed [X_W-1:0]   r_x;
    logic                    r_neg;
    logic [DEG_W-1:0]        r_deg;
    logic [DEG_W-1:0]        r_cnt;
    // recurrence state
    logic [A_W-1:0]          r_ma;
    logic                    r_aneg;
    logic signed [OUT_W-1:0] r_v0, r_v1;
    logic [OUT_W-1:0]        r_mv1;
    logic                    r_v1neg;
    logic                    r_ovf;
    logic [ACC_W-1:0]        r_acc;
    logic signed [S_W-1:0]   r_s;
    // zero-argument result
    logic signed [OUT_W-1:0] r_zres;
    logic                    r_zsat;
    // result
    logic signed [OUT_W-1:0] r_poly;
    logic                    r_sat;

    // load: degree clamp
    logic [C_W-1:0]   deg_ext;
    logic [DEG_W-1:0] n_deg;
    assign deg_ext = C_W'(i_degree[DEG_IN_W-2:0]);
    assign n_deg   = (deg_ext > C_MAXDEG) ? DEG_W'(C_MAXDEG) : DEG_W'(deg_ext);

    // prep: a = 4x-2, V1 = 4x-3, both signs computed side by side
    logic signed [A_W-1:0] x4, a_p, a_n, v_p, v_n;
    logic                  v_over, v_under;
    logic [OUT_W-1:0]      n_v1, n_mv1;
    assign x4  = A_W'(r_x) <<< 2;
    assign a_p = x4 - C_TWO;
    assign a_n = C_TWO - x4;
    assign v_p = x4 - C_THREE;
    assign v_n = C_THREE - x4;

    always_comb begin
        v_over  = !v_p[A_W-1] && (V_W'($unsigned(v_p)) > V_W'(OUT_MAX));
        v_under =  v_p[A_W-1] && (V_W'($unsigned(v_n)) > V_W'(OUT_MIN));
        if (v_over) begin
            n_v1  = OUT_MAX;
            n_mv1 = OUT_MAX;
        end else if (v_under) begin
            n_v1  = OUT_MIN;
            n_mv1 = OUT_MIN;
        end else begin
            n_v1  = OUT_W'(v_p);
            n_mv1 = v_p[A_W-1] ? OUT_W'(v_n) : OUT_W'(v_p);
        end
    end

    // prep: x == 0 gives +/-(2n+1)
    logic [Z_W-1:0]   zm;
    logic             z_sat;
    logic [OUT_W-1:0] n_zres;
    assign zm = Z_W'({r_deg, 1'b1}) << FRAC_BITS;

    always_comb begin
        z_sat = r_deg[0] ? (zm > Z_W'(OUT_MIN)) : (zm > Z_W'(OUT_MAX));
        if (z_sat) begin
            n_zres = r_deg[0] ? OUT_MIN : OUT_MAX;
        end else begin
            n_zres = r_deg[0] ? (OUT_W'(0) - OUT_W'(zm)) : OUT_W'(zm);
        end
    end

    // mul: one digit of |V1| per cycle, rounding half preloaded
    logic [DIG_W-1:0]       digit;
    logic [A_W+DIG_W-1:0]   pp;
    logic [ACC_W-1:0]       acc_base, n_acc;
    assign digit    = r_mv1[i_cmd.dig * DIG_W +: DIG_W];
    assign pp       = r_ma * digit;
    assign acc_base = (i_cmd.dig == '0) ? C_HALF : r_acc;
    assign n_acc    = acc_base + (ACC_W'(pp) << (i_cmd.dig * DIG_W));

    // rnd: scale down, clamp magnitude, apply sign
    logic [M_W-1:0]        m_raw, m_clip;
    logic signed [S_W-1:0] n_s;
    assign m_raw  = r_acc[ACC_W-1:FRAC_BITS];
    assign m_clip = (m_raw > C_BIG) ? C_BIG : m_raw;
    assign n_s    = (r_aneg ^ r_v1neg) ? (S_W'(0) - S_W'(m_clip)) : S_W'(m_clip);

    // upd: V(k+1) = s - V(k-1), saturated
    logic signed [N_W-1:0] nv, nvn;
    logic                  u_over, u_under;
    logic [OUT_W-1:0]      n_nv, n_nmag;
    assign nv  = N_W'(r_s) - N_W'(r_v0);
    assign nvn = N_W'(r_v0) - N_W'(r_s);

    always_comb begin
        u_over  = !nv[N_W-1] && ($unsigned(nv) > N_W'(OUT_MAX));
        u_under =  nv[N_W-1] && ($unsigned(nvn) > N_W'(OUT_MIN));
        if (u_over) begin
            n_nv   = OUT_MAX;
            n_nmag = OUT_MAX;
        end else if (u_under) begin
            n_nv   = OUT_MIN;
            n_nmag = OUT_MIN;
        end else begin
            n_nv   = nv[OUT_W-1:0];
            n_nmag = nv[N_W-1] ? nvn[OUT_W-1:0] : nv[OUT_W-1:0];
        end
    end

    // finish: result select
    logic [OUT_W-1:0] n_poly;
    logic             n_sat;
    always_comb begin
        case (i_cmd.sel)
            SEL_ZERO: begin
                n_poly = '0;
                n_sat  = 1'b0;
            end
            SEL_ONE: begin
                n_poly = C_ONE_O;
                n_sat  = 1'b0;
            end
            SEL_XZERO: begin
                n_poly = r_zres;
                n_sat  = r_zsat;
            end
            SEL_V0: begin
                n_poly = r_v0;
                n_sat  = r_ovf;
            end
            SEL_V1: begin
                n_poly = r_v1;
                n_sat  = r_ovf;
            end
            default: begin
                n_poly = '0;
                n_sat  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_x_value;
            r_neg <= i_degree[DEG_IN_W-1];
            r_deg <= n_deg;
        end
        if (i_cmd.prep) begin
            r_aneg  <= a_p[A_W-1];
            r_ma    <= a_p[A_W-1] ? a_n : a_p;
            r_v0    <= C_ONE_O;
            r_v1    <= n_v1;
            r_mv1   <= n_mv1;
            r_v1neg <= v_p[A_W-1];
            r_ovf   <= v_over | v_under;
            r_cnt   <= r_deg - 1'b1;
            r_zres  <= n_zres;
            r_zsat  <= z_sat;
        end
        if (i_cmd.mul) begin
            r_acc <= n_acc;
        end
        if (i_cmd.rnd) begin
            r_s <= n_s;
        end
        if (i_cmd.upd) begin
            r_v0    <= r_v1;
            r_v1    <= n_nv;
            r_mv1   <= n_nmag;
            r_v1neg <= nv[N_W-1];
            r_ovf   <= u_over | u_under;
            r_cnt   <= r_cnt - 1'b1;
        end
        if (i_cmd.finish) begin
            r_poly <= n_poly;
            r_sat  <= n_sat;
        end
    end

    assign o_status.deg_neg  = r_neg;
    assign o_status.x_one    = (A_W'(r_x) == C_ONE);
    assign o_status.x_zero   = (r_x == '0);
    assign o_status.n_zero   = (r_deg == '0);
    assign o_status.n_one    = (r_deg == DEG_W'(1));
    assign o_status.v1_ovf   = r_ovf;
    assign o_status.step_ovf = u_over | u_under;
    assign o_status.cnt_last = (r_cnt == DEG_W'(1));

    assign o_poly_value = r_poly;
    assign o_saturated  = r_sat;

endmodule

[src/shifted_chebyshev_v_eval.sv]
// Shifted Chebyshev polynomial of the third kind, V*n(x), in fixed point.
// The special cases (negative degree, x = 1, x = 0, n = 0, n = 1, saturated 4x-3) go
// straight from the decision to the o_valid strobe; otherwise the recurrence loop runs.
// Each recurrence step runs two 24-bit multiplier digits, then round, then update.
// A new item can be accepted in the strobe cycle; o_valid is one cycle, no stall.
// Synchronous active-low reset returns the controller to idle, strobe low.
`timescale 1ns / 1ps

module shifted_chebyshev_v_eval #(
    parameter int MAX_DEGREE = scv_pkg::DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = scv_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [scv_pkg::X_W-1:0]      i_x_value,
    input  logic signed [scv_pkg::DEG_IN_W-1:0] i_degree,
    output logic                                o_valid,
    output logic signed [scv_pkg::OUT_W-1:0]    o_poly_value,
    output logic                                o_saturated
);
    import scv_pkg::*;

    // Controller sequences load, operand prep, special-case decision and the
    // recurrence loop; datapath holds all operands and the result register.
    t_dp_cmd    cmd;
    t_dp_status status;

    scv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Recurrence V(k+1) = (4x-2)V(k) - V(k-1); product rounded half away
    // from zero, clamped at 2^50, each new V saturated to 48 bits.
    scv_dpath #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_x_value    (i_x_value),
        .i_degree     (i_degree),
        .o_status     (status),
        .o_poly_value (o_poly_value),
        .o_saturated  (o_saturated)
    );

endmodule

[sim/shifted_chebyshev_v_eval_tb.sv]
// Self-checking testbench for shifted_chebyshev_v_eval: directed corner items, then random
// items in several sender idle phases, each result checked against an in-bench predictor.
// Depends on src/scv_pkg.sv and src/shifted_chebyshev_v_eval.sv.
`timescale 1ns / 1ps

// Holds the expected V*n(x) values in accept order and checks each strobed result.
class poly_scoreboard;
    localparam int     FRAC    = scv_pkg::DEF_FRAC_BITS;
    localparam int     MAX_DEG = scv_pkg::DEF_MAX_DEGREE;
    localparam longint ONE     = longint'(1) << FRAC;
    localparam longint BIG     = longint'(1) << scv_pkg::BIG_LOG;
    localparam longint V_MAX   = (longint'(1) << (scv_pkg::OUT_W - 1)) - 1;
    localparam longint V_MIN   = -V_MAX - 1;

    typedef struct {
        logic signed [scv_pkg::OUT_W-1:0] poly_value;
        logic                             saturated;
    } t_poly_result;

    t_poly_result expected_polys[$];
    int unsigned  failures = 0;

    function longint clip_to_out(longint v, inout bit ovf);
        if (v > V_MAX) begin
            ovf = 1'b1;
            return V_MAX;
        end
        if (v < V_MIN) begin
            ovf = 1'b1;
            return V_MIN;
        end
        return v;
    endfunction

    // Product rounded to FRAC fraction bits, ties away from zero, magnitude capped at BIG.
    function longint round_mul(longint a, longint b);
        bit                  neg;
        longint unsigned     ma;
        longint unsigned     mb;
        logic [127:0]        q;
        longint unsigned     m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : a;
        mb  = (b < 0) ? longint'(-b) : b;
        q   = {64'd0, ma} * {64'd0, mb} + (128'd1 << (FRAC - 1));
        if (q[127:64+FRAC] != 0) begin
            m = BIG;
        end else begin
            m = q[64+FRAC-1:FRAC];
            if (m > BIG) m = BIG;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function t_poly_result eval_v_star(logic signed [scv_pkg::X_W-1:0] x_in,
                                       logic signed [scv_pkg::DEG_IN_W-1:0] deg_in);
        t_poly_result r;
        longint       xv;
        longint       n;
        longint       a;
        longint       v0;
        longint       v1;
        longint       nv;
        longint       res;
        bit           ovf;
        xv  = x_in;
        n   = deg_in;
        res = 0;
        ovf = 1'b0;
        if (n >= 0) begin
            if (n > MAX_DEG) n = MAX_DEG;
            if (xv == ONE) begin
                res = ONE;
            end else if (xv == 0) begin
                res = clip_to_out(n[0] ? -(2 * n + 1) * ONE : (2 * n + 1) * ONE, ovf);
            end else begin
                a  = 4 * xv - 2 * ONE;
                v0 = ONE;
                v1 = clip_to_out(a - ONE, ovf);
                if (n == 0) begin
                    res = v0;
                end else begin
                    for (longint k = 2; k <= n && !ovf; k++) begin
                        nv = clip_to_out(round_mul(a, v1) - v0, ovf);
                        v0 = v1;
                        v1 = nv;
                    end
                    res = v1;
                end
            end
        end
        r.poly_value = res[scv_pkg::OUT_W-1:0];
        r.saturated  = ovf;
        return r;
    endfunction

    function void note_item(logic signed [scv_pkg::X_W-1:0] x_in,
                            logic signed [scv_pkg::DEG_IN_W-1:0] deg_in);
        expected_polys.push_back(eval_v_star(x_in, deg_in));
    endfunction

    function void check_result(logic signed [scv_pkg::OUT_W-1:0] poly_value,
                               logic saturated);
        t_poly_result e;
        if (expected_polys.size() == 0) begin
            $error("result with no item pending: poly_value %0d saturated %0b",
                   poly_value, saturated);
            failures++;
            return;
        end
        e = expected_polys.pop_front();
        if (poly_value !== e.poly_value) begin
            $error("poly_value: expected %0d, got %0d", e.poly_value, poly_value);
            failures++;
        end
        if (saturated !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, saturated);
            failures++;
        end
    endfunction

    function int pending();
        return expected_polys.size();
    endfunction
endclass

module shifted_chebyshev_v_eval_tb;
    import scv_pkg::*;

    localparam longint ONE_Q   = longint'(1) << DEF_FRAC_BITS;
    localparam int     LIMIT   = 4_000_000;  // timeout in cycles for the whole run
    localparam int     N_PHASE = 4;
    localparam int     PHASE_N = 175;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [X_W-1:0]      i_x_value;
    logic signed [DEG_IN_W-1:0] i_degree;
    logic                       o_valid;
    logic signed [OUT_W-1:0]    o_poly_value;
    logic                       o_saturated;

    poly_scoreboard sb = new();
    int unsigned    cycle_count = 0;
    int unsigned    idle_pct = 0;  // percent of cycles the sender holds off before an item

    shifted_chebyshev_v_eval i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_x_value    (i_x_value),
        .i_degree     (i_degree),
        .o_valid      (o_valid),
        .o_poly_value (o_poly_value),
        .o_saturated  (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Accepts and results are sampled at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_item(i_x_value, i_degree);
        if (i_rst_n && o_valid) sb.check_result(o_poly_value, o_saturated);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("shifted_chebyshev_v_eval regression: fail");
            $finish;
        end
    end

    // Random idle before the item, with junk on the fields; then hold until accepted.
    task automatic send_item(input logic signed [X_W-1:0] xv,
                             input logic signed [DEG_IN_W-1:0] dv);
        while ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            i_x_value <= $urandom;
            i_degree  <= DEG_IN_W'($urandom);
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_x_value <= xv;
        i_degree  <= dv;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        int unsigned          pick;
        logic signed [31:0]   xr;
        logic signed [8:0]    dr;
        int unsigned          pcts[N_PHASE];

        // receiver stalls cannot happen, so those phases reduce to sender idling only
        pcts      = '{0, 79, 0, 12};
        start     <= 1'b0;
        i_x_value <= '0;
        i_degree  <= '0;
        i_rst_n   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n   <= 1'b1;

        // negative degree wins over every argument
        send_item(32'sd0, -9'sd1);
        send_item(32'(ONE_Q), -9'sd256);
        send_item(32'h7fff_ffff, -9'sd77);
        // argument exactly one
        send_item(32'(ONE_Q), 9'sd0);
        send_item(32'(ONE_Q), 9'sd5);
        send_item(32'(ONE_Q), 9'sd255);
        // argument exactly zero: sign follows parity of n
        send_item(32'sd0, 9'sd0);
        send_item(32'sd0, 9'sd1);
        send_item(32'sd0, 9'sd2);
        send_item(32'sd0, 9'sd255);
        // degree zero and one off the special arguments
        send_item(32'h8000_0000, 9'sd0);
        send_item(32'h7fff_ffff, 9'sd1);
        send_item(32'h8000_0000, 9'sd1);
        // extremes at full degree saturate, plus the low extreme at degree 2
        send_item(32'h7fff_ffff, 9'sd255);
        send_item(32'h8000_0000, 9'sd255);
        send_item(32'h8000_0000, 9'sd2);
        // x = 1/2 makes 4x-2 zero; neighbors of one stay bounded or creep outward
        send_item(32'(ONE_Q / 2), 9'sd9);
        send_item(32'(ONE_Q + 1), 9'sd255);
        send_item(32'(ONE_Q - 1), 9'sd100);
        send_item(-32'(ONE_Q), 9'sd3);
        send_item(32'(ONE_Q / 3), 9'sd255);
        send_item(32'sd1, 9'sd2);

        for (int p = 0; p < N_PHASE; p++) begin
            idle_pct = pcts[p];
            for (int i = 0; i < PHASE_N; i++) begin
                // mostly modest degrees, a few near the top of the range
                pick = $urandom_range(99);
                if (pick < 8)        dr = -9'($urandom_range(256, 1));
                else if (pick < 11)  dr = 9'($urandom_range(255, 200));
                else if (pick < 26)  dr = 9'($urandom_range(2, 0));
                else                 dr = 9'($urandom_range(40, 3));
                // mostly x in [0, 1] where the recurrence stays in range
                pick = $urandom_range(99);
                if (pick < 50)       xr = 32'($urandom_range(32'(ONE_Q), 0));
                else if (pick < 55)  xr = 32'sd0;
                else if (pick < 60)  xr = 32'(ONE_Q);
                else if (pick < 75)  xr = 32'(ONE_Q) - 32'sd16777216
                                          + 32'($urandom_range(32'(ONE_Q) + 33554432, 0));
                else                 xr = $urandom;
                send_item(xr, dr);
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("shifted_chebyshev_v_eval regression: pass");
        end else begin
            $display("shifted_chebyshev_v_eval regression: fail");
        end
        $finish;
    end
endmodule

[shifted_chebyshev_v_eval.f]
src/scv_pkg.sv
src/scv_ctrl.sv
src/scv_dpath.sv
src/shifted_chebyshev_v_eval.sv
sim/shifted_chebyshev_v_eval_tb.sv
